// File: rtl/bloom_filter_double_hash_unit_assert.svh
// ----------------------------------------------------------------------------
// Bloom filter double hash unit: assertion macros
// Shared concurrent assertion forms for the checker of the unit.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_DOUBLE_HASH_UNIT_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_UNIT_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define BFDH_ASSERT_SAME(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("bloom filter unit: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define BFDH_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("bloom filter unit: next-cycle check failed");

`endif

// File: rtl/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter double hash package
// Shared widths, codes, state encoding and control/status bundles.
// ----------------------------------------------------------------------------
package bfdh_pkg;

   localparam int HASH_W     = 64;
   localparam int MOD_W      = 17;
   localparam int PC_W       = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam int DEF_MAX_BITS   = 65536;
   localparam int DEF_MAX_PROBES = 16;
   localparam int MIN_PROBES     = 2;
   localparam int RESET_PROBES   = 2;
   localparam int RESET_BITS     = 65536;

   // Residues are built four hash bits per cycle.
   localparam int DIG_BITS  = 4;
   localparam int DIG_N     = HASH_W / DIG_BITS;
   localparam int DIG_CNT_W = $clog2(DIG_N);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_BITS = 2'd1;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_DIV    = 6'b000100,
      ST_FIX    = 6'b001000,
      ST_PROBE  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic div_step;
      logic fix;
      logic probe_wr;
      logic probe_rd;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_last;
      logic issue_done;
      logic rd_pending;
      logic miss;
   } dp_stat_type;

endpackage

// File: rtl/bfdh_datapath.sv
// ----------------------------------------------------------------------------
// Bloom filter double hash datapath
// Residue lanes, incremental probe position, bit store and clear counter.
// ----------------------------------------------------------------------------
module bfdh_datapath #(
   parameter int MAX_BITS   = bfdh_pkg::DEF_MAX_BITS,
   parameter int MAX_PROBES = bfdh_pkg::DEF_MAX_PROBES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bfdh_pkg::dp_cmd_type        cmd,
   output bfdh_pkg::dp_stat_type       stat,
   input  logic [bfdh_pkg::HASH_W-1:0] first_hash,
   input  logic [bfdh_pkg::HASH_W-1:0] second_hash,
   input  logic [$clog2(MAX_PROBES+1)-1:0] probes,
   input  logic [bfdh_pkg::MOD_W-1:0]  modulus
);

   localparam int AW = $clog2(MAX_BITS);
   localparam int CW = $clog2(MAX_PROBES + 1);
   localparam int MW = bfdh_pkg::MOD_W;
   localparam int HW = bfdh_pkg::HASH_W;

   // One remainder step per hash bit, four bits per call.
   function automatic logic [MW-1:0] mod_digit(input logic [MW-1:0] r,
                                                input logic [bfdh_pkg::DIG_BITS-1:0] d,
                                                input logic [MW-1:0] m);
      logic [MW:0]   t;
      logic [MW-1:0] acc;
      acc = r;
      for (int i = bfdh_pkg::DIG_BITS - 1; i >= 0; i--) begin
         t = {acc, d[i]};
         if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
         end
         acc = t[MW-1:0];
      end
      return acc;
   endfunction

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [HW-1:0] h1_sh_ff, h1_sh_in, h2_sh_ff, h2_sh_in;
   logic [HW-1:0] h_ff, h_in, step_ff, step_in;
   logic [MW-1:0] r1_ff, r1_in, r2_ff, r2_in, ra_ff, ra_in;
   logic [bfdh_pkg::DIG_CNT_W-1:0] dig_ff, dig_in;
   logic [MW-1:0] pos_ff, pos_in, s_ff, s_in, c_ff, c_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          rd_data_ff;
   logic          issue;
   logic [MW:0]   sum, p1, p2, a1;
   logic [HW:0]   hsum;
   logic          mem_we, mem_wd, mem_re;
   logic [AW-1:0] mem_wa;

   logic bit_mem [MAX_BITS];

   always_comb begin
      issue = (cmd.probe_wr | cmd.probe_rd) && (cnt_ff != probes);

      // Next position modulo m; a wrap of the 64-bit sum removes 2^64 mod m.
      sum  = {1'b0, pos_ff} + {1'b0, s_ff};
      p1   = (sum >= {1'b0, modulus}) ? (sum - {1'b0, modulus}) : sum;
      hsum = {1'b0, h_ff} + {1'b0, step_ff};
      if (!hsum[HW]) begin
         p2 = p1;
      end else if (p1 >= {1'b0, c_ff}) begin
         p2 = p1 - {1'b0, c_ff};
      end else begin
         p2 = p1 + {1'b0, modulus} - {1'b0, c_ff};
      end

      a1 = {1'b0, ra_ff} + {{MW{1'b0}}, 1'b1};

      clr_addr_in = clr_addr_ff;
      h1_sh_in    = h1_sh_ff;
      h2_sh_in    = h2_sh_ff;
      h_in        = h_ff;
      step_in     = step_ff;
      r1_in       = r1_ff;
      r2_in       = r2_ff;
      ra_in       = ra_ff;
      dig_in      = dig_ff;
      pos_in      = pos_ff;
      s_in        = s_ff;
      c_in        = c_ff;
      cnt_in      = cnt_ff;

      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end
      if (cmd.load) begin
         h1_sh_in = first_hash;
         h2_sh_in = second_hash;
         h_in     = first_hash;
         step_in  = second_hash;
         r1_in    = '0;
         r2_in    = '0;
         ra_in    = '0;
         dig_in   = '0;
      end
      if (cmd.div_step) begin
         r1_in    = mod_digit(r1_ff, h1_sh_ff[HW-1 -: bfdh_pkg::DIG_BITS], modulus);
         r2_in    = mod_digit(r2_ff, h2_sh_ff[HW-1 -: bfdh_pkg::DIG_BITS], modulus);
         ra_in    = mod_digit(ra_ff, '1, modulus);
         h1_sh_in = h1_sh_ff << bfdh_pkg::DIG_BITS;
         h2_sh_in = h2_sh_ff << bfdh_pkg::DIG_BITS;
         dig_in   = dig_ff + bfdh_pkg::DIG_CNT_W'(1);
      end
      if (cmd.fix) begin
         pos_in = r1_ff;
         s_in   = r2_ff;
         c_in   = (a1 == {1'b0, modulus}) ? '0 : a1[MW-1:0];
         cnt_in = '0;
      end
      if (issue) begin
         pos_in = p2[MW-1:0];
         h_in   = hsum[HW-1:0];
         cnt_in = cnt_ff + CW'(1);
      end

      rd_valid_in = issue && cmd.probe_rd;

      mem_we = cmd.clear_step || (issue && cmd.probe_wr);
      mem_wd = !cmd.clear_step;
      mem_wa = cmd.clear_step ? clr_addr_ff : AW'(pos_ff);
      mem_re = issue && cmd.probe_rd;

      stat.clear_last = (clr_addr_ff == AW'(MAX_BITS - 1));
      stat.div_last   = (dig_ff == bfdh_pkg::DIG_CNT_W'(bfdh_pkg::DIG_N - 1));
      stat.issue_done = (cnt_ff == probes);
      stat.rd_pending = rd_valid_ff;
      stat.miss       = rd_valid_ff && !rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         rd_valid_ff <= 1'b0;
         dig_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         rd_valid_ff <= rd_valid_in;
         dig_ff      <= dig_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      h1_sh_ff <= h1_sh_in;
      h2_sh_ff <= h2_sh_in;
      h_ff     <= h_in;
      step_ff  <= step_in;
      r1_ff    <= r1_in;
      r2_ff    <= r2_in;
      ra_ff    <= ra_in;
      pos_ff   <= pos_in;
      s_ff     <= s_in;
      c_ff     <= c_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bit_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= bit_mem[AW'(pos_ff)];
      end
   end

endmodule

// File: rtl/bfdh_ctrl.sv
// ----------------------------------------------------------------------------
// Bloom filter double hash controller
// Sequences clearing, residue build, probing and result delivery.
// ----------------------------------------------------------------------------
module bfdh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output bfdh_pkg::dp_cmd_type  cmd,
   input  bfdh_pkg::dp_stat_type stat
);

   bfdh_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;
   logic query_ff, query_in;
   logic found_ff, found_in;

   always_comb begin
      state_in     = state_ff;
      query_in     = query_ff;
      found_in     = found_ff;
      rsp_found_in = rsp_found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;

      unique case (state_ff)
         bfdh_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = bfdh_pkg::ST_IDLE;
            end
         end
         bfdh_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               query_in = (req_cmd == bfdh_pkg::CMD_QUERY);
               state_in = bfdh_pkg::ST_DIV;
            end
         end
         bfdh_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = bfdh_pkg::ST_FIX;
            end
         end
         bfdh_pkg::ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = bfdh_pkg::ST_PROBE;
         end
         bfdh_pkg::ST_PROBE: begin
            cmd.probe_wr = !query_ff;
            cmd.probe_rd = query_ff;
            if (stat.miss) begin
               found_in = 1'b0;
               state_in = bfdh_pkg::ST_FINISH;
            end else if (stat.issue_done && !stat.rd_pending) begin
               found_in = query_ff;
               state_in = bfdh_pkg::ST_FINISH;
            end
         end
         bfdh_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               state_in     = bfdh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfdh_pkg::ST_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != bfdh_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfdh_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      query_ff     <= query_in;
      found_ff     <= found_in;
   end

endmodule

// File: rtl/bloom_filter_double_hash_unit.sv
// ----------------------------------------------------------------------------
// Bloom filter double hash unit
// Bloom filter engine that inserts or queries keys given as two hashes.
// ----------------------------------------------------------------------------
// Usage. A request word carries a command (insert or query) and two 64-bit
// key hashes. It is taken at a clock edge where req_valid is high and
// req_stall is low. Each request returns exactly one response word on the
// rsp channel; rsp_found is 1 only for a query whose probed bits were all set.
// Probe positions are (first + i * second) mod m for i = 0 .. k-1, with the
// 64-bit sums wrapping. Steps: the two hash residues are built four bits per
// cycle, a setup step follows, then one probe per cycle through the bit
// store, a check that the probes are complete (for a query, once its last
// read has returned), then the response register is loaded. A query that
// meets a clear bit ends early. The unit takes one request at a time. A
// response that the receiver stalls holds in the output register while the
// next request is already accepted and worked on.
// After reset the bit store is swept to zero, one bit per cycle, over all
// MAX_BITS bits; req_stall stays high during the sweep. Registers may be
// written at any time, including during the sweep, while no request is open.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_unit #(
   parameter int MAX_BITS   = bfdh_pkg::DEF_MAX_BITS,
   parameter int MAX_PROBES = bfdh_pkg::DEF_MAX_PROBES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [bfdh_pkg::HASH_W-1:0]     req_first_hash,
   input  logic [bfdh_pkg::HASH_W-1:0]     req_second_hash,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   input  logic                            csr_wr_en,
   input  logic [bfdh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfdh_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_PROBES + 1);

   logic [bfdh_pkg::PC_W-1:0]  probe_count_ff, probe_count_in;
   logic [bfdh_pkg::MOD_W-1:0] filter_bits_ff, filter_bits_in;
   logic [CW-1:0]              probes;
   logic [bfdh_pkg::MOD_W-1:0] modulus;
   bfdh_pkg::dp_cmd_type       dp_cmd;
   bfdh_pkg::dp_stat_type      dp_stat;

   // Register writes; an index with no register behind it is ignored.
   always_comb begin
      probe_count_in = probe_count_ff;
      filter_bits_in = filter_bits_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bfdh_pkg::CSR_PROBE_COUNT: probe_count_in = csr_wdata[bfdh_pkg::PC_W-1:0];
            bfdh_pkg::CSR_FILTER_BITS: filter_bits_in = csr_wdata[bfdh_pkg::MOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_count_ff <= bfdh_pkg::PC_W'(bfdh_pkg::RESET_PROBES);
         filter_bits_ff <= bfdh_pkg::MOD_W'(bfdh_pkg::RESET_BITS);
      end else begin
         probe_count_ff <= probe_count_in;
         filter_bits_ff <= filter_bits_in;
      end
   end

   // Out-of-range settings are clamped: k to [2, MAX_PROBES], m to [1, MAX_BITS].
   always_comb begin
      if (32'(probe_count_ff) < bfdh_pkg::MIN_PROBES) begin
         probes = CW'(bfdh_pkg::MIN_PROBES);
      end else if (32'(probe_count_ff) > MAX_PROBES) begin
         probes = CW'(MAX_PROBES);
      end else begin
         probes = CW'(probe_count_ff);
      end

      if (filter_bits_ff == '0) begin
         modulus = bfdh_pkg::MOD_W'(1);
      end else if (32'(filter_bits_ff) > MAX_BITS) begin
         modulus = bfdh_pkg::MOD_W'(MAX_BITS);
      end else begin
         modulus = filter_bits_ff;
      end
   end

   bfdh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_found (rsp_found),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   bfdh_datapath #(
      .MAX_BITS   (MAX_BITS),
      .MAX_PROBES (MAX_PROBES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .stat        (dp_stat),
      .first_hash  (req_first_hash),
      .second_hash (req_second_hash),
      .probes      (probes),
      .modulus     (modulus)
   );

endmodule

// File: rtl/bfdh_checker.sv
// ----------------------------------------------------------------------------
// Bloom filter double hash checker
// Port-level assertions on the unit, attached to every instance by bind.
// ----------------------------------------------------------------------------
`include "bloom_filter_double_hash_unit_assert.svh"

module bfdh_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_found
);

   logic       req_acc, rsp_acc;
   logic [1:0] open_ff, open_in;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // Words accepted and not yet answered.
   always_comb begin
      open_in = open_ff;
      if (req_acc && !rsp_acc) begin
         open_in = open_ff + 2'd1;
      end else if (!req_acc && rsp_acc) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   `BFDH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `BFDH_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_found))
   `BFDH_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_acc, req_stall)
   `BFDH_ASSERT_SAME(a_no_extra_rsp, clock, reset, rsp_acc, open_ff != 2'd0)
   `BFDH_ASSERT_SAME(a_sweep_stall, clock, 1'b0, $past(reset), req_stall)

endmodule

bind bloom_filter_double_hash_unit bfdh_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_found (rsp_found)
);

// File: tb/bloom_filter_double_hash_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bloom filter double hash unit testbench
// Drives insert and query words into the unit and checks every found flag
// against a bit-accurate copy of the filter store kept in the bench. A short
// directed table comes first, then randomized phases under several register
// settings, with random idling on both channels and one long response stall.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_unit_tb;

   // Register indexes that the unit does not decode; writes there must be ignored.
   localparam logic [bfdh_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [bfdh_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_WORDS   = 88;
   localparam int PHASE_COUNT   = 8;
   localparam int HOLD_AT       = 120;
   localparam int HOLD_CYCLES   = 400;
   localparam int CALM_PHASE    = 4;
   localparam int POOL_DEPTH    = 64;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct {
      bit                             is_reg;
      logic [bfdh_pkg::CSR_IDX_W-1:0] reg_idx;
      bit [bfdh_pkg::CSR_DATA_W-1:0]  reg_value;
      logic                           cmd;
      bit [bfdh_pkg::HASH_W-1:0]      first;
      bit [bfdh_pkg::HASH_W-1:0]      second;
      bit                             known;
      bit                             known_found;
   } stim_row_type;

   typedef struct {
      bit [bfdh_pkg::HASH_W-1:0] first;
      bit [bfdh_pkg::HASH_W-1:0] second;
   } key_pair_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_cmd = bfdh_pkg::CMD_INSERT;
   logic [bfdh_pkg::HASH_W-1:0]     req_first_hash = '0;
   logic [bfdh_pkg::HASH_W-1:0]     req_second_hash = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_found;
   logic                            csr_wr_en = 1'b0;
   logic [bfdh_pkg::CSR_IDX_W-1:0]  csr_index = bfdh_pkg::CSR_PROBE_COUNT;
   logic [bfdh_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Bench copy of the filter: the bit store and both registers.
   bit                            filter_store [bfdh_pkg::DEF_MAX_BITS];
   bit [bfdh_pkg::PC_W-1:0]       probes_reg = bfdh_pkg::PC_W'(bfdh_pkg::RESET_PROBES);
   bit [bfdh_pkg::CSR_DATA_W-1:0] bits_reg = bfdh_pkg::CSR_DATA_W'(bfdh_pkg::RESET_BITS);

   bit           pending_found [$];
   stim_row_type directed_rows [$];
   key_pair_type key_pool [$];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  words_sent = 0;
   int  inserts_sent = 0;
   int  queries_sent = 0;
   int  results_seen = 0;
   int  hits_seen = 0;
   int  settings_used = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  calm = 1'b0;

   bloom_filter_double_hash_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_first_hash  (req_first_hash),
      .req_second_hash (req_second_hash),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   // The run is cut off here if the unit ever stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Applies one word to the bench copy of the store and returns its found flag.
   // Probe counts below two act as two and above the maximum act as the maximum;
   // a modulus of zero acts as one and anything above the store size is clipped.
   // A query quits at the first clear bit, an insert sets every probed bit.
   function automatic bit probe_filter(logic cmd, bit [bfdh_pkg::HASH_W-1:0] first,
                                       bit [bfdh_pkg::HASH_W-1:0] second);
      int                        probes;
      bit [bfdh_pkg::HASH_W-1:0] span;
      bit [bfdh_pkg::HASH_W-1:0] walk;
      bit [bfdh_pkg::HASH_W-1:0] pos;
      bit                        hit;
      probes = (probes_reg < bfdh_pkg::MIN_PROBES) ? bfdh_pkg::MIN_PROBES :
               (probes_reg > bfdh_pkg::DEF_MAX_PROBES) ? bfdh_pkg::DEF_MAX_PROBES :
               int'(probes_reg);
      span = (bits_reg == 0) ? 64'd1 :
             (bits_reg > bfdh_pkg::DEF_MAX_BITS) ? 64'(bfdh_pkg::DEF_MAX_BITS) :
             64'(bits_reg);
      walk = first;
      hit = (cmd == bfdh_pkg::CMD_QUERY);
      for (int i = 0; i < probes; i++) begin
         pos = walk % span;
         if (cmd == bfdh_pkg::CMD_INSERT) begin
            filter_store[pos] = 1'b1;
         end else if (!filter_store[pos]) begin
            hit = 1'b0;
            break;
         end
         walk = walk + second;
      end
      return hit;
   endfunction

   // Hash values lean on the edges now and then: zero, all ones and tiny values.
   function automatic bit [bfdh_pkg::HASH_W-1:0] pick_hash();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return bfdh_pkg::HASH_W'($urandom_range(255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic row_word(logic cmd, bit [bfdh_pkg::HASH_W-1:0] first,
                           bit [bfdh_pkg::HASH_W-1:0] second,
                           bit known, bit known_found);
      stim_row_type row;
      row = '{1'b0, bfdh_pkg::CSR_PROBE_COUNT, '0, cmd, first, second, known, known_found};
      directed_rows.push_back(row);
   endtask

   task automatic row_reg(logic [bfdh_pkg::CSR_IDX_W-1:0] idx,
                          bit [bfdh_pkg::CSR_DATA_W-1:0] value);
      stim_row_type row;
      row = '{1'b1, idx, value, bfdh_pkg::CMD_INSERT, '0, '0, 1'b0, 1'b0};
      directed_rows.push_back(row);
   endtask

   // Offers one word and returns in the time step of the edge that took it.
   // The expectation is queued at that edge, so a typed-in value, where one is
   // given, replaces the predicted answer while the bench store still sees the word.
   task automatic send_word(logic cmd, bit [bfdh_pkg::HASH_W-1:0] first,
                            bit [bfdh_pkg::HASH_W-1:0] second,
                            bit known, bit known_found);
      bit predicted;
      if (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_first_hash  <= first;
      req_second_hash <= second;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = probe_filter(cmd, first, second);
      pending_found.push_back(known ? known_found : predicted);
      words_sent++;
      if (cmd == bfdh_pkg::CMD_INSERT) inserts_sent++;
      else queries_sent++;
   endtask

   // The sender stops and waits until every response has come back.
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (pending_found.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [bfdh_pkg::CSR_IDX_W-1:0] idx,
                            bit [bfdh_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == bfdh_pkg::CSR_PROBE_COUNT) probes_reg = value[bfdh_pkg::PC_W-1:0];
      else if (idx == bfdh_pkg::CSR_FILTER_BITS) bits_reg = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Response side: checks each taken word against the oldest expectation and
   // chooses the stall for the next cycle. Once, after a fixed number of
   // responses, it holds off for a long stretch so the unit backs up.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         results_seen++;
         if (rsp_found === 1'b1) hits_seen++;
         if (pending_found.size() == 0) begin
            $error("response word arrived with no request outstanding");
            fail_count++;
         end else if (rsp_found !== pending_found[0]) begin
            $error("found mismatch: expected %0d, actual %0d", pending_found[0], rsp_found);
            fail_count++;
            void'(pending_found.pop_front());
         end else begin
            void'(pending_found.pop_front());
         end
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && $urandom_range(99) < 22;
      end
   end

   initial begin
      int                        pc_set [PHASE_COUNT];
      int                        fb_set [PHASE_COUNT];
      int                        sel;
      key_pair_type              pair;
      bit [bfdh_pkg::HASH_W-1:0] first_a;
      bit [bfdh_pkg::HASH_W-1:0] second_a;

      // Directed words. Typed-in answers: an empty store misses, an insert
      // always answers zero, a one-bit filter sees only bit zero, and writes
      // to the spare indexes change nothing. Each register change leaves the
      // store untouched while later probes use the new settings.
      row_word(bfdh_pkg::CMD_QUERY,  '0, '0, 1'b1, 1'b0);
      row_word(bfdh_pkg::CMD_INSERT, '0, '0, 1'b1, 1'b0);
      row_word(bfdh_pkg::CMD_QUERY,  '0, '0, 1'b1, 1'b1);
      row_word(bfdh_pkg::CMD_QUERY,  '1, '1, 1'b0, 1'b0);
      row_word(bfdh_pkg::CMD_INSERT, '1, '1, 1'b1, 1'b0);
      row_word(bfdh_pkg::CMD_QUERY,  '1, '1, 1'b0, 1'b0);
      row_word(bfdh_pkg::CMD_INSERT, 64'd1, '1, 1'b1, 1'b0);
      row_word(bfdh_pkg::CMD_QUERY,  64'd1, '1, 1'b0, 1'b0);
      row_reg(bfdh_pkg::CSR_PROBE_COUNT, 17'd0);
      row_reg(bfdh_pkg::CSR_FILTER_BITS, 17'd0);
      row_word(bfdh_pkg::CMD_QUERY,  64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
               1'b1, 1'b1);
      row_word(bfdh_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
               1'b1, 1'b0);
      row_reg(bfdh_pkg::CSR_PROBE_COUNT, 17'd31);
      row_reg(bfdh_pkg::CSR_FILTER_BITS, 17'h1FFFF);
      row_word(bfdh_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
               1'b1, 1'b0);
      row_word(bfdh_pkg::CMD_QUERY,  64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
               1'b0, 1'b0);
      row_word(bfdh_pkg::CMD_QUERY,  64'h8000_0000_0000_0000, 64'h5555_5555_5555_5556,
               1'b0, 1'b0);
      row_reg(CSR_SPARE_A, 17'd0);
      row_reg(CSR_SPARE_B, 17'd5);
      row_word(bfdh_pkg::CMD_QUERY,  64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
               1'b0, 1'b0);
      row_reg(bfdh_pkg::CSR_PROBE_COUNT, 17'd1);
      row_reg(bfdh_pkg::CSR_FILTER_BITS, 17'd1);
      row_word(bfdh_pkg::CMD_QUERY,  64'hDEAD_BEEF_0000_0001, 64'd1, 1'b1, 1'b1);
      row_reg(bfdh_pkg::CSR_PROBE_COUNT, 17'd16);
      row_reg(bfdh_pkg::CSR_FILTER_BITS, 17'd65536);
      row_word(bfdh_pkg::CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0001_0001,
               1'b1, 1'b0);
      row_word(bfdh_pkg::CMD_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0001_0001,
               1'b0, 1'b0);
      row_reg(bfdh_pkg::CSR_PROBE_COUNT, 17'd17);
      row_reg(bfdh_pkg::CSR_FILTER_BITS, 17'd65537);
      row_word(bfdh_pkg::CMD_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0001_0001,
               1'b0, 1'b0);
      row_word(bfdh_pkg::CMD_QUERY,  '1, '0, 1'b0, 1'b0);
      row_reg(bfdh_pkg::CSR_PROBE_COUNT, 17'd2);
      row_reg(bfdh_pkg::CSR_FILTER_BITS, 17'd64);
      row_word(bfdh_pkg::CMD_QUERY,  64'h40, 64'h80, 1'b0, 1'b0);
      row_word(bfdh_pkg::CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0,
               1'b1, 1'b0);
      row_word(bfdh_pkg::CMD_QUERY,  64'h7FFF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0,
               1'b0, 1'b0);

      // Register settings for the random phases, the extremes among them.
      pc_set = '{2, 16, 4, 0, 8, 31, 3, 16};
      fb_set = '{65536, 64, 1000, 0, 4096, 131071, 2, 65536};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The unit sweeps its store after reset and holds req_stall meanwhile,
      // so the first word simply waits for the handshake.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_reg) begin
            settle_idle();
            write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_value);
            settings_used++;
         end else begin
            send_word(directed_rows[r].cmd, directed_rows[r].first, directed_rows[r].second,
                      directed_rows[r].known, directed_rows[r].known_found);
         end
      end

      // Random phases. Most queries reuse inserted keys, whole or by start only, so the found
      // path and the partial miss path (same start, other step) both see use.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle_idle();
         write_reg(bfdh_pkg::CSR_PROBE_COUNT, bfdh_pkg::CSR_DATA_W'(pc_set[p]));
         write_reg(bfdh_pkg::CSR_FILTER_BITS, bfdh_pkg::CSR_DATA_W'(fb_set[p]));
         if ($urandom_range(1)) write_reg(CSR_SPARE_B, bfdh_pkg::CSR_DATA_W'($urandom));
         settings_used++;
         calm = (p == CALM_PHASE);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            sel = $urandom_range(99);
            if (sel < 40 || key_pool.size() == 0) begin
               pair.first  = pick_hash();
               pair.second = pick_hash();
               key_pool.push_back(pair);
               if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
               send_word(bfdh_pkg::CMD_INSERT, pair.first, pair.second, 1'b0, 1'b0);
            end else if (sel < 70) begin
               pair = key_pool[$urandom_range(key_pool.size() - 1)];
               send_word(bfdh_pkg::CMD_QUERY, pair.first, pair.second, 1'b0, 1'b0);
            end else if (sel < 85) begin
               pair = key_pool[$urandom_range(key_pool.size() - 1)];
               second_a = pick_hash();
               send_word(bfdh_pkg::CMD_QUERY, pair.first, second_a, 1'b0, 1'b0);
            end else begin
               first_a  = pick_hash();
               second_a = pick_hash();
               send_word(bfdh_pkg::CMD_QUERY, first_a, second_a, 1'b0, 1'b0);
            end
         end
         calm = 1'b0;
      end

      settle_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words (%0d inserts, %0d queries) over %0d register settings.",
               words_sent, inserts_sent, queries_sent, settings_used);
      $display("Checked %0d responses, %0d of them reporting a hit.", results_seen, hits_seen);
      if (fail_count == 0 && pending_found.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
